/* rtl/ppu_pkg.sv */
// ppu_pkg: shared constants, types and saturation helpers for particle_pool_update
// depends on nothing; used by ppu_alu, particle_pool_update, the checker and the test bench
package ppu_pkg;

    localparam int POOL   = 64;
    localparam int ADDR_W = (POOL > 1) ? $clog2(POOL) : 1;
    localparam int CNT_W  = $clog2(POOL + 1);

    localparam int LIFE_MS      = 1000;
    localparam int SPAWN_BIAS   = 200000;
    localparam int JITTER_UNIT  = 1000;
    localparam int GREY_BASE    = 5000;
    localparam int GREY_STEP    = 100;
    localparam int SHADE_MAX    = 99;
    localparam int ALPHA_FULL   = 10000;
    localparam int ALPHA_PER_MS = 25;

    localparam logic OP_SPAWN    = 1'b0;
    localparam logic OP_TICK     = 1'b1;
    localparam logic KIND_SPAWN  = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    typedef struct packed {
        logic        [9:0]  life;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [13:0] grey;
        logic signed [14:0] alpha;
    } entry_t;

    typedef struct packed {
        entry_t ent;
        logic   alive;
    } tick_t;

    typedef struct packed {
        logic               kind;
        logic        [5:0]  slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [13:0] grey;
        logic signed [14:0] opacity;
        logic               last;
    } out_rec_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SEARCH = 6'b000010,
        ST_SPAWN  = 6'b000100,
        ST_UPDATE = 6'b001000,
        ST_SCAN   = 6'b010000,
        ST_LOAD   = 6'b100000
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -34'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [14:0] sat15(input logic signed [22:0] v);
        logic signed [14:0] r;
        if (v > 23'sd16383)
            r = 15'sh3FFF;
        else if (v < -23'sd16384)
            r = 15'sh4000;
        else
            r = v[14:0];
        return r;
    endfunction

endpackage

/* rtl/ppu_ifc.sv */
// ppu_ifc: valid/ready channels for particle_pool_update commands and results
// depends on nothing
interface ppu_cmd_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [6:0]  jitter;
    logic        [6:0]  shade;
    logic signed [30:0] offset_x;
    logic signed [30:0] offset_y;
    logic        [15:0] elapsed_ms;

    modport source (output valid, opcode, jitter, shade, offset_x, offset_y, elapsed_ms,
                    input ready);
    modport sink   (input valid, opcode, jitter, shade, offset_x, offset_y, elapsed_ms,
                    output ready);
endinterface

interface ppu_res_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic        [5:0]  slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [13:0] grey;
    logic signed [14:0] opacity;
    logic               last;

    modport source (output valid, kind, slot, pos_x, pos_y, grey, opacity, last,
                    input ready);
    modport sink   (input valid, kind, slot, pos_x, pos_y, grey, opacity, last,
                     output ready);
endinterface

/* rtl/ppu_ram.sv */
// ppu_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
module ppu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/ppu_alu.sv */
// ppu_alu: spawn field computation and per-slot tick update arithmetic
// depends on ppu_pkg
module ppu_alu (
    input  logic signed [6:0]  jitter,
    input  logic        [6:0]  shade,
    input  logic signed [30:0] offset_x,
    input  logic signed [30:0] offset_y,
    input  ppu_pkg::entry_t    cur,
    input  logic        [15:0] dt,
    output ppu_pkg::entry_t    spawn_ent,
    output ppu_pkg::tick_t     tick_res
);
    import ppu_pkg::*;

    logic signed [17:0] jit_ext;
    logic signed [17:0] jit_k;
    logic signed [33:0] sum_x;
    logic signed [33:0] sum_y;
    logic        [6:0]  shade_c;
    logic signed [33:0] mv_x;
    logic signed [33:0] mv_y;
    logic        [20:0] fade;
    logic signed [22:0] a_diff;

    // spawn
    always_comb
    begin
        jit_ext = 18'(jitter);
        jit_k   = jit_ext * 18'sd1000;
        sum_x   = 34'(offset_x) + 34'(jit_k) + 34'(SPAWN_BIAS);
        sum_y   = 34'(offset_y) + 34'(jit_k) + 34'(SPAWN_BIAS);
        shade_c = (shade > 7'(SHADE_MAX)) ? 7'(SHADE_MAX) : shade;
        spawn_ent.life  = 10'(LIFE_MS);
        spawn_ent.pos_x = sat32(sum_x);
        spawn_ent.pos_y = sat32(sum_y);
        spawn_ent.grey  = 14'(GREY_BASE) + 14'(shade_c) * 14'(GREY_STEP);
        spawn_ent.alpha = 15'(ALPHA_FULL);
    end

    // tick
    always_comb
    begin
        mv_x   = 34'(cur.pos_x) - $signed(34'(dt));
        mv_y   = 34'(cur.pos_y) - $signed(34'(dt));
        fade   = 21'(dt) * 21'(ALPHA_PER_MS);
        a_diff = 23'(cur.alpha) - $signed(23'(fade));
        tick_res.alive     = ({6'd0, cur.life} > dt);
        tick_res.ent.life  = cur.life - dt[9:0];
        tick_res.ent.pos_x = sat32(mv_x);
        tick_res.ent.pos_y = sat32(mv_y);
        tick_res.ent.grey  = cur.grey;
        tick_res.ent.alpha = sat15(a_diff);
    end

endmodule

/* rtl/particle_pool_update.sv */
// particle_pool_update: top level, sequencer, live bitmap, particle ram and result register
// depends on ppu_pkg, ppu_ifc, ppu_ram, ppu_alu
//
// One command transaction is taken at a time; cmd.ready is high only while the sequencer
// is idle. A spawn walks the live bitmap one slot per cycle from the search cursor to a
// free slot, or takes slot 0 when every slot is live, and then loads its report. A tick
// makes one read-modify-write pass over the particle ram, one slot per cycle; if any
// particle stays live it then scans the bitmap one slot per cycle up to the last live
// slot, reading each live particle from ram, then loading it into the result register.
// A held result register adds stall cycles only when the next result is ready to load.
// Slots are tracked by a live bitmap cleared at reset, so the ram needs no clearing pass.
module particle_pool_update (
    input logic        clk,
    input logic        rst_n,
    ppu_cmd_if.sink    cmd,
    ppu_res_if.source  res
);
    import ppu_pkg::*;

    state_t              state_reg, state_next;
    logic [POOL-1:0]     live_reg, live_next;
    logic [ADDR_W-1:0]   cursor_reg, cursor_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ADDR_W-1:0]   last_idx_reg, last_idx_next;
    logic                any_reg, any_next;
    logic [15:0]         dt_reg, dt_next;
    entry_t              spawn_reg, spawn_next;
    logic                out_valid_reg, out_valid_next;
    out_rec_t            out_reg, out_next;

    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    entry_t              rd_data;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    entry_t              wr_data;

    entry_t              spawn_ent;
    tick_t               tick_res;
    logic [CNT_W-1:0]    cnt_m1;
    logic [ADDR_W-1:0]   upd_idx;
    logic                out_free;

    ppu_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (POOL)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ppu_alu u_alu (
        .jitter    (cmd.jitter),
        .shade     (cmd.shade),
        .offset_x  (cmd.offset_x),
        .offset_y  (cmd.offset_y),
        .cur       (rd_data),
        .dt        (dt_reg),
        .spawn_ent (spawn_ent),
        .tick_res  (tick_res)
    );

    assign cmd.ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || res.ready;
    assign cnt_m1    = cnt_reg - 1'b1;
    assign upd_idx   = cnt_m1[ADDR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        live_next      = live_reg;
        cursor_next    = cursor_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        last_idx_next  = last_idx_reg;
        any_next       = any_reg;
        dt_next        = dt_reg;
        spawn_next     = spawn_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_next       = out_reg;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg[ADDR_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = spawn_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    cnt_next = '0;
                    if (cmd.opcode == OP_SPAWN)
                    begin
                        spawn_next = spawn_ent;
                        idx_next   = cursor_reg;
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        dt_next    = cmd.elapsed_ms;
                        any_next   = 1'b0;
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (!live_reg[idx_reg])
                begin
                    state_next = ST_SPAWN;
                end
                else if (cnt_reg == CNT_W'(POOL - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_SPAWN;
                end
                else
                begin
                    idx_next   = (idx_reg == ADDR_W'(POOL - 1)) ? '0 : idx_reg + 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            ST_SPAWN:
            begin
                if (out_free)
                begin
                    wr_en             = 1'b1;
                    live_next[idx_reg] = 1'b1;
                    cursor_next       = idx_reg;
                    out_valid_next    = 1'b1;
                    out_next.kind     = KIND_SPAWN;
                    out_next.slot     = 6'(idx_reg);
                    out_next.pos_x    = spawn_reg.pos_x;
                    out_next.pos_y    = spawn_reg.pos_y;
                    out_next.grey     = spawn_reg.grey;
                    out_next.opacity  = spawn_reg.alpha;
                    out_next.last     = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_UPDATE:
            begin
                // read slot cnt while writing back slot cnt-1
                rd_en = (cnt_reg < CNT_W'(POOL));
                if (cnt_reg != '0 && live_reg[upd_idx])
                begin
                    if (tick_res.alive)
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = upd_idx;
                        wr_data       = tick_res.ent;
                        any_next      = 1'b1;
                        last_idx_next = upd_idx;
                    end
                    else
                    begin
                        live_next[upd_idx] = 1'b0;
                    end
                end
                if (cnt_reg == CNT_W'(POOL))
                begin
                    idx_next   = '0;
                    state_next = any_next ? ST_SCAN : ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (live_reg[idx_reg])
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg;
                    state_next = ST_LOAD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_next.kind    = KIND_RECORD;
                    out_next.slot    = 6'(idx_reg);
                    out_next.pos_x   = rd_data.pos_x;
                    out_next.pos_y   = rd_data.pos_y;
                    out_next.grey    = rd_data.grey;
                    out_next.opacity = rd_data.alpha;
                    out_next.last    = (idx_reg == last_idx_reg);
                    if (idx_reg == last_idx_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            live_reg      <= '0;
            cursor_reg    <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            last_idx_reg  <= '0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            cursor_reg    <= cursor_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            last_idx_reg  <= last_idx_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg    <= dt_next;
        spawn_reg <= spawn_next;
        out_reg   <= out_next;
    end

    assign res.valid   = out_valid_reg;
    assign res.kind    = out_reg.kind;
    assign res.slot    = out_reg.slot;
    assign res.pos_x   = out_reg.pos_x;
    assign res.pos_y   = out_reg.pos_y;
    assign res.grey    = out_reg.grey;
    assign res.opacity = out_reg.opacity;
    assign res.last    = out_reg.last;

endmodule

/* rtl/ppu_checker.sv */
// ppu_checker: port-level assertions for particle_pool_update, with its bind
// depends on ppu_pkg and particle_pool_update
module ppu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic               res_kind,
    input logic        [5:0]  res_slot,
    input logic signed [31:0] res_pos_x,
    input logic signed [31:0] res_pos_y,
    input logic        [13:0] res_grey,
    input logic signed [14:0] res_opacity,
    input logic               res_last
);
    import ppu_pkg::*;

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_slot) && $stable(res_pos_x)
            && $stable(res_pos_y) && $stable(res_opacity) && $stable(res_last))
        else $error("result changed while stalled");

    // one command in flight
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while busy");

    // spawn report is a single, fresh particle
    a_spawn: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_SPAWN |-> res_last
            && res_opacity == 15'(ALPHA_FULL)
            && res_grey >= 14'(GREY_BASE) && res_grey <= 14'd14900)
        else $error("bad spawn report");

    // live records come from spawned particles, never brighter than at spawn
    a_record: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_RECORD |-> res_grey >= 14'(GREY_BASE)
            && res_opacity <= 15'(ALPHA_FULL))
        else $error("bad particle record");

endmodule

bind particle_pool_update ppu_checker u_ppu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_kind    (res.kind),
    .res_slot    (res.slot),
    .res_pos_x   (res.pos_x),
    .res_pos_y   (res.pos_y),
    .res_grey    (res.grey),
    .res_opacity (res.opacity),
    .res_last    (res.last)
);

/* dv/particle_pool_update_test.sv */
// particle_pool_update_test: self-checking bench for the particle pool, spawn and tick commands
// depends on ppu_pkg, ppu_ifc and particle_pool_update from the rtl folder
// a clocked driver feeds queued transactions; a clocked monitor checks results against a predictor
module particle_pool_update_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ppu_pkg::*;

    localparam int QUIET_TAIL     = 50;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int RANDOM_ITEMS   = 390;

    typedef struct {
        logic               op;
        logic signed [6:0]  jitter;
        logic        [6:0]  shade;
        logic signed [30:0] offset_x;
        logic signed [30:0] offset_y;
        logic        [15:0] elapsed_ms;
    } pool_cmd_t;

    logic clk;
    logic rst_n;

    ppu_cmd_if cmd_ch();
    ppu_res_if res_ch();

    particle_pool_update u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // predicted pool contents
    int                 slot_life  [POOL];
    logic signed [31:0] slot_x     [POOL];
    logic signed [31:0] slot_y     [POOL];
    logic        [13:0] slot_grey  [POOL];
    logic signed [14:0] slot_alpha [POOL];
    int                 next_fit;

    pool_cmd_t pending_cmds[$];
    out_rec_t  expected_results[$];
    pool_cmd_t cur_cmd;
    int        send_gap;
    int        stall_left;
    int        idle_cycles;
    int        errors;

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void apply_command(input pool_cmd_t c);
        longint   jit;
        int       shade_used;
        int       hit;
        int       last_live;
        int       dt;
        int       i;
        out_rec_t r;
        if (c.op == OP_SPAWN)
        begin
            hit = -1;
            for (i = next_fit; i < POOL && hit < 0; i++)
                if (slot_life[i] == 0)
                    hit = i;
            for (i = 0; i < next_fit && hit < 0; i++)
                if (slot_life[i] == 0)
                    hit = i;
            if (hit < 0)
                hit = 0;
            next_fit = hit;
            jit = longint'(c.jitter) * JITTER_UNIT;
            shade_used = (c.shade > SHADE_MAX) ? SHADE_MAX : int'(c.shade);
            slot_life[hit]  = LIFE_MS;
            slot_x[hit]     = 32'(clamp(longint'(c.offset_x) + jit + SPAWN_BIAS,
                                        -64'sd2147483648, 64'sd2147483647));
            slot_y[hit]     = 32'(clamp(longint'(c.offset_y) + jit + SPAWN_BIAS,
                                        -64'sd2147483648, 64'sd2147483647));
            slot_grey[hit]  = 14'(GREY_BASE + shade_used * GREY_STEP);
            slot_alpha[hit] = 15'(ALPHA_FULL);
            r.kind    = KIND_SPAWN;
            r.slot    = 6'(hit);
            r.pos_x   = slot_x[hit];
            r.pos_y   = slot_y[hit];
            r.grey    = slot_grey[hit];
            r.opacity = slot_alpha[hit];
            r.last    = 1'b1;
            expected_results = {expected_results, r};
        end
        else
        begin
            dt = int'(c.elapsed_ms);
            last_live = -1;
            for (i = 0; i < POOL; i++)
            begin
                slot_life[i] = (slot_life[i] > dt) ? slot_life[i] - dt : 0;
                if (slot_life[i] > 0)
                begin
                    slot_x[i] = 32'(clamp(longint'(slot_x[i]) - dt,
                                          -64'sd2147483648, 64'sd2147483647));
                    slot_y[i] = 32'(clamp(longint'(slot_y[i]) - dt,
                                          -64'sd2147483648, 64'sd2147483647));
                    slot_alpha[i] = 15'(clamp(longint'(slot_alpha[i])
                                              - longint'(dt) * ALPHA_PER_MS, -16384, 16383));
                    last_live = i;
                end
            end
            for (i = 0; i < POOL; i++)
            begin
                if (slot_life[i] > 0)
                begin
                    r.kind    = KIND_RECORD;
                    r.slot    = 6'(i);
                    r.pos_x   = slot_x[i];
                    r.pos_y   = slot_y[i];
                    r.grey    = slot_grey[i];
                    r.opacity = slot_alpha[i];
                    r.last    = (i == last_live);
                    expected_results = {expected_results, r};
                end
            end
        end
    endfunction

    function automatic void push_spawn(input logic [6:0] jitter, input logic [6:0] shade,
                                       input logic [30:0] ox, input logic [30:0] oy,
                                       input logic [15:0] elapsed_ms);
        pool_cmd_t c;
        c.op         = OP_SPAWN;
        c.jitter     = jitter;
        c.shade      = shade;
        c.offset_x   = ox;
        c.offset_y   = oy;
        c.elapsed_ms = elapsed_ms;
        pending_cmds = {pending_cmds, c};
    endfunction

    function automatic void push_tick(input logic [15:0] elapsed_ms);
        pool_cmd_t c;
        c.op         = OP_TICK;
        c.jitter     = 7'($urandom);
        c.shade      = 7'($urandom);
        c.offset_x   = 31'($urandom);
        c.offset_y   = 31'($urandom);
        c.elapsed_ms = elapsed_ms;
        pending_cmds = {pending_cmds, c};
    endfunction

    function automatic void push_random_spawn();
        push_spawn(7'($urandom), 7'($urandom), 31'($urandom), 31'($urandom), 16'($urandom));
    endfunction

    task automatic report_field(input string name, input logic signed [31:0] exp_v,
                                input logic signed [31:0] got_v);
        $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, got_v);
        errors++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.opcode      = OP_SPAWN;
        cmd_ch.jitter      = '0;
        cmd_ch.shade       = '0;
        cmd_ch.offset_x    = '0;
        cmd_ch.offset_y    = '0;
        cmd_ch.elapsed_ms  = '0;
        res_ch.ready       = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // stimulus: directed corners, then spawn bursts mixed with ticks
    initial
    begin
        int rnd_count;
        int n;
        bit overflow_done;
        for (int i = 0; i < POOL; i++)
        begin
            slot_life[i]  = 0;
            slot_x[i]     = '0;
            slot_y[i]     = '0;
            slot_grey[i]  = '0;
            slot_alpha[i] = '0;
        end
        next_fit    = 0;
        send_gap    = 0;
        stall_left  = 0;
        idle_cycles = 0;
        errors      = 0;

        push_tick(16'd0);
        push_spawn(-7'sd64, 7'd0, 31'h4000_0000, 31'h3FFF_FFFF, 16'd0);
        push_spawn(7'sd63, 7'd99, 31'h3FFF_FFFF, 31'h4000_0000, 16'd12);
        push_spawn(7'sd0, 7'd100, 31'd0, 31'd0, 16'd0);
        push_spawn(-7'sd50, 7'd127, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
        push_spawn(7'sd49, 7'd50, 31'h2AAA_AAAA, 31'h5555_5555, 16'h5555);
        push_tick(16'd0);
        push_tick(16'd1);
        push_tick(16'd998);
        push_tick(16'd1);
        push_spawn(7'sd1, 7'd1, 31'd1, 31'h7FFF_FFFE, 16'd0);
        push_spawn(-7'sd1, 7'd98, 31'h7FFF_FFFF, 31'd1, 16'd0);
        push_tick(16'd999);
        push_tick(16'hFFFF);
        push_spawn(7'sd10, 7'd20, 31'd100, 31'd200, 16'd0);
        push_tick(16'd1000);
        push_spawn(-7'sd10, 7'd30, 31'd300, 31'd400, 16'd0);
        push_tick(16'd1001);
        push_spawn(7'sd5, 7'd64, 31'h1234_5678, 31'h6543_2100, 16'hAAAA);
        push_tick(16'h8000);

        rnd_count = 0;
        overflow_done = 0;
        while (rnd_count < RANDOM_ITEMS)
        begin
            if (!overflow_done && rnd_count > 120)
            begin
                // more spawns than slots, no tick in between
                for (int i = 0; i < POOL + 6; i++)
                    push_random_spawn();
                push_tick(16'($urandom_range(0, 50)));
                rnd_count += POOL + 7;
                overflow_done = 1;
            end
            case ($urandom_range(0, 9))
                0:
                begin
                    push_tick(16'($urandom));
                    rnd_count++;
                end
                1:
                begin
                    push_tick(16'($urandom_range(995, 1005)));
                    rnd_count++;
                end
                default:
                begin
                    n = $urandom_range(1, 8);
                    for (int i = 0; i < n; i++)
                        push_random_spawn();
                    rnd_count += n;
                    n = $urandom_range(1, 2);
                    for (int i = 0; i < n; i++)
                        push_tick(16'($urandom_range(0, 300)));
                    rnd_count += n;
                end
            endcase
        end
    end

    // command driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                apply_command(cur_cmd);
                if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 3);
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (send_gap > 0 || pending_cmds.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap--;
                    cmd_ch.valid <= 1'b0;
                end
                else
                begin
                    cur_cmd = pending_cmds.pop_front();
                    cmd_ch.valid      <= 1'b1;
                    cmd_ch.opcode     <= cur_cmd.op;
                    cmd_ch.jitter     <= cur_cmd.jitter;
                    cmd_ch.shade      <= cur_cmd.shade;
                    cmd_ch.offset_x   <= cur_cmd.offset_x;
                    cmd_ch.offset_y   <= cur_cmd.offset_y;
                    cmd_ch.elapsed_ms <= cur_cmd.elapsed_ms;
                end
            end
        end
    end

    // result back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        out_rec_t exp_r;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected transaction: slot %0d kind %0d", $time,
                         res_ch.slot, res_ch.kind);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (res_ch.kind !== exp_r.kind)
                    report_field("kind", exp_r.kind, res_ch.kind);
                if (res_ch.slot !== exp_r.slot)
                    report_field("slot", exp_r.slot, res_ch.slot);
                if (res_ch.pos_x !== exp_r.pos_x)
                    report_field("pos_x", exp_r.pos_x, res_ch.pos_x);
                if (res_ch.pos_y !== exp_r.pos_y)
                    report_field("pos_y", exp_r.pos_y, res_ch.pos_y);
                if (res_ch.grey !== exp_r.grey)
                    report_field("grey", exp_r.grey, res_ch.grey);
                if (res_ch.opacity !== exp_r.opacity)
                    report_field("opacity", exp_r.opacity, res_ch.opacity);
                if (res_ch.last !== exp_r.last)
                    report_field("last", exp_r.last, res_ch.last);
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d commands and %0d results outstanding",
                         $time, pending_cmds.size(), expected_results.size());
                $display("particle_pool_update_test: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_ch.valid)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("particle_pool_update_test: PASS");
        else
            $display("particle_pool_update_test: FAIL");
        $finish;
    end

endmodule
